// ===== hw/rtl/mbld_pkg.sv =====
// Shared types and constants for the multi-button lockout debouncer.
package mbld_pkg;

    localparam int NOTE_COUNT     = 7;
    localparam int SELECTOR_COUNT = 3;
    localparam int TIME_BITS      = 32;
    localparam int NOW_W          = 32;
    localparam int BUTTON_W       = 4;
    localparam int LOCKOUT_W      = 16;
    localparam int NOTE_INDEX_W   = 3;
    localparam int NOTE_IDX_W     = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd120;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_SLOT = 2'd1,
        EV_NEXT = 2'd2,
        EV_PREV = 2'd3
    } sel_event_t;

    // One input item as held in the input register.
    typedef struct packed {
        logic [TIME_BITS-1:0] now;
        logic                 edge_valid;
        logic [BUTTON_W-1:0]  edge_button;
        logic                 poll_notes;
        logic                 poll_selector;
        logic                 take_event;
    } item_t;

endpackage

// ===== hw/rtl/mbld_note_scan.sv =====
// Note button pending flags, timestamps and the lowest-index-first scan.
module mbld_note_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  mbld_pkg::item_t                     item,
    input  logic [mbld_pkg::LOCKOUT_W-1:0]      lockout,
    output logic                                note_valid,
    output logic [mbld_pkg::NOTE_INDEX_W-1:0]   note_index
);

    logic [mbld_pkg::NOTE_COUNT-1:0] pending_reg;
    logic [mbld_pkg::NOTE_COUNT-1:0] pending_next;
    logic [mbld_pkg::TIME_BITS-1:0]  stamp_reg  [mbld_pkg::NOTE_COUNT];
    logic [mbld_pkg::TIME_BITS-1:0]  stamp_next [mbld_pkg::NOTE_COUNT];
    logic [mbld_pkg::NOTE_COUNT-1:0] pend;
    logic [mbld_pkg::NOTE_COUNT-1:0] passed;
    logic [mbld_pkg::NOTE_IDX_W-1:0] win_idx;
    logic                            done;

    always_comb
    begin
        pend    = pending_reg;
        done    = 1'b0;
        win_idx = '0;
        for (int i = 0; i < mbld_pkg::NOTE_COUNT; i++)
        begin
            if (item.edge_valid && (int'(item.edge_button) == i))
            begin
                pend[i] = 1'b1;
            end
            passed[i] = ((item.now - stamp_reg[i])
                         >= mbld_pkg::TIME_BITS'(lockout));
            stamp_next[i] = stamp_reg[i];
        end
        pending_next = pend;
        // visited flags clear; scan stops at the first note past its lockout
        if (item.poll_notes)
        begin
            for (int i = 0; i < mbld_pkg::NOTE_COUNT; i++)
            begin
                if (!done && pend[i])
                begin
                    pending_next[i] = 1'b0;
                    if (passed[i])
                    begin
                        done          = 1'b1;
                        win_idx       = mbld_pkg::NOTE_IDX_W'(i);
                        stamp_next[i] = item.now;
                    end
                end
            end
        end
        note_valid = done;
        note_index = mbld_pkg::NOTE_INDEX_W'(win_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            for (int i = 0; i < mbld_pkg::NOTE_COUNT; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            for (int i = 0; i < mbld_pkg::NOTE_COUNT; i++)
            begin
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/mbld_sel_scan.sv =====
// Selector button flags, timestamps, latched event and event take.
module mbld_sel_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  mbld_pkg::item_t                 item,
    input  logic [mbld_pkg::LOCKOUT_W-1:0]  lockout,
    output mbld_pkg::sel_event_t            selector_event
);

    logic [mbld_pkg::SELECTOR_COUNT-1:0] pending_reg;
    logic [mbld_pkg::SELECTOR_COUNT-1:0] pending_next;
    logic [mbld_pkg::TIME_BITS-1:0]      stamp_reg  [mbld_pkg::SELECTOR_COUNT];
    logic [mbld_pkg::TIME_BITS-1:0]      stamp_next [mbld_pkg::SELECTOR_COUNT];
    logic [mbld_pkg::SELECTOR_COUNT-1:0] pend;
    logic [mbld_pkg::SELECTOR_COUNT-1:0] acc;
    mbld_pkg::sel_event_t                event_reg;
    mbld_pkg::sel_event_t                event_next;
    mbld_pkg::sel_event_t                scanned;

    always_comb
    begin
        pend = pending_reg;
        for (int i = 0; i < mbld_pkg::SELECTOR_COUNT; i++)
        begin
            if (item.edge_valid
                && (int'(item.edge_button) == mbld_pkg::NOTE_COUNT + i))
            begin
                pend[i] = 1'b1;
            end
            acc[i] = pend[i] && ((item.now - stamp_reg[i])
                                 >= mbld_pkg::TIME_BITS'(lockout));
            stamp_next[i] = (item.poll_selector && acc[i]) ? item.now : stamp_reg[i];
        end
        pending_next = item.poll_selector ? '0 : pend;

        // highest accepted selector wins
        scanned = event_reg;
        if (item.poll_selector)
        begin
            if (acc[0])
            begin
                scanned = mbld_pkg::EV_SLOT;
            end
            if (acc[1])
            begin
                scanned = mbld_pkg::EV_NEXT;
            end
            if (acc[2])
            begin
                scanned = mbld_pkg::EV_PREV;
            end
        end

        if (item.take_event)
        begin
            selector_event = scanned;
            event_next     = mbld_pkg::EV_NONE;
        end
        else
        begin
            selector_event = mbld_pkg::EV_NONE;
            event_next     = scanned;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            event_reg   <= mbld_pkg::EV_NONE;
            for (int i = 0; i < mbld_pkg::SELECTOR_COUNT; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            event_reg   <= event_next;
            for (int i = 0; i < mbld_pkg::SELECTOR_COUNT; i++)
            begin
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/multi_button_lockout_debouncer_unit.sv =====
// Top level of the multi-button lockout debouncer.
//
// Input channel (in_valid / in_stall) carries one item per transfer: the
// current time, an optional falling edge on one of seven note buttons or
// three selector buttons, and requests to poll notes, poll selectors and
// take the latched selector event. Every item gives exactly one result on
// the output channel (out_valid / out_stall): note_valid, note_index and
// selector_event.
// The input register feeds the single-pass scan logic, which updates all
// button state and loads the result register. Throughput is one item per
// cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; one more item may
// sit in the input register, after which in_stall rises.
// lockout_ms is written through cfg_write / cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears all pending flags, timestamps and the latched event, and sets lockout_ms to 120.
module multi_button_lockout_debouncer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mbld_pkg::LOCKOUT_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mbld_pkg::NOW_W-1:0]          now_ms,
    input  logic                                edge_valid,
    input  logic [mbld_pkg::BUTTON_W-1:0]       edge_button,
    input  logic                                poll_notes,
    input  logic                                poll_selector,
    input  logic                                take_event,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                note_valid,
    output logic [mbld_pkg::NOTE_INDEX_W-1:0]   note_index,
    output logic [1:0]                          selector_event
);

    logic [mbld_pkg::LOCKOUT_W-1:0]    lockout_reg;
    logic                              s1_valid_reg;
    mbld_pkg::item_t                   s1_item_reg;
    logic                              out_valid_reg;
    logic                              note_valid_reg;
    logic [mbld_pkg::NOTE_INDEX_W-1:0] note_index_reg;
    mbld_pkg::sel_event_t              sel_event_reg;

    logic                              advance;
    logic                              accept;
    logic                              fire;
    logic                              scan_note_valid;
    logic [mbld_pkg::NOTE_INDEX_W-1:0] scan_note_index;
    mbld_pkg::sel_event_t              scan_sel_event;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign fire     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= mbld_pkg::LOCKOUT_RESET;
        end
        else if (cfg_write)
        begin
            lockout_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.now           <= now_ms[mbld_pkg::TIME_BITS-1:0];
            s1_item_reg.edge_valid    <= edge_valid;
            s1_item_reg.edge_button   <= edge_button;
            s1_item_reg.poll_notes    <= poll_notes;
            s1_item_reg.poll_selector <= poll_selector;
            s1_item_reg.take_event    <= take_event;
        end
    end

    mbld_note_scan u_note_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (s1_item_reg),
        .lockout    (lockout_reg),
        .note_valid (scan_note_valid),
        .note_index (scan_note_index)
    );

    mbld_sel_scan u_sel_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (s1_item_reg),
        .lockout        (lockout_reg),
        .selector_event (scan_sel_event)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            note_valid_reg <= scan_note_valid;
            note_index_reg <= scan_note_index;
            sel_event_reg  <= scan_sel_event;
        end
    end

    assign out_valid      = out_valid_reg;
    assign note_valid     = note_valid_reg;
    assign note_index     = note_index_reg;
    assign selector_event = sel_event_reg;

endmodule
